>>> rtl/core/gkre_pkg.sv
// Shared types, constants and lookup tables for the Gaussian kernel row evaluator.
package gkre_pkg;

  localparam int CoordBits = 16;
  localparam int ScaleBits = 16;
  localparam int CountBits = 7;
  localparam int IndexBits = 6;
  localparam int KernelBits = 16;

  typedef enum logic {
    CfgActiveLocations = 1'b0,
    CfgInvScaleSq      = 1'b1
  } cfg_index_e;

  typedef enum logic {
    OpLoad     = 1'b0,
    OpEvaluate = 1'b1
  } op_e;

  typedef struct packed {
    logic                        operation;
    logic [IndexBits-1:0]        slot;
    logic signed [CoordBits-1:0] coord_x;
    logic signed [CoordBits-1:0] coord_y;
  } in_word_t;

  typedef struct packed {
    logic [IndexBits-1:0]  location_index;
    logic [KernelBits-1:0] kernel_value;
    logic                  last;
  } out_word_t;

  // Tag that follows one location down the kernel pipeline
  typedef struct packed {
    logic [IndexBits-1:0] index;
    logic                 last;
  } loc_tag_t;

  // Exponent at or beyond 12.0 (Q.16) gives a zero kernel value
  localparam logic [19:0] CutoffU = 20'd786432;

  // round(65536 * exp(-k/16)), k = 0..16
  function automatic logic [16:0] fr_lut(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd61565;
      5'd2:    v = 17'd57835;
      5'd3:    v = 17'd54331;
      5'd4:    v = 17'd51039;
      5'd5:    v = 17'd47947;
      5'd6:    v = 17'd45042;
      5'd7:    v = 17'd42313;
      5'd8:    v = 17'd39750;
      5'd9:    v = 17'd37341;
      5'd10:   v = 17'd35079;
      5'd11:   v = 17'd32954;
      5'd12:   v = 17'd30957;
      5'd13:   v = 17'd29081;
      5'd14:   v = 17'd27319;
      5'd15:   v = 17'd25664;
      5'd16:   v = 17'd24109;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // round(2^24 * exp(-n)), n = 0..11
  function automatic logic [24:0] it_lut(input logic [3:0] n);
    logic [24:0] v;
    case (n)
      4'd0:    v = 25'd16777216;
      4'd1:    v = 25'd6171993;
      4'd2:    v = 25'd2270549;
      4'd3:    v = 25'd835288;
      4'd4:    v = 25'd307285;
      4'd5:    v = 25'd113044;
      4'd6:    v = 25'd41587;
      4'd7:    v = 25'd15299;
      4'd8:    v = 25'd5628;
      4'd9:    v = 25'd2070;
      4'd10:   v = 25'd762;
      4'd11:   v = 25'd280;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/gaussian_kernel_row_evaluator_unit.sv
// Top level of the Gaussian kernel row evaluator: location memory, sequencer, output word.
// A load word writes one (x, y) location into the location memory. An evaluate word reads
// locations 0 .. active_locations-1 from that memory, one per cycle while the output is
// not stalled, and sends each through a four-stage kernel pipeline, which yields one
// kernel word per cycle under the same condition. Input words are taken only when no
// evaluation is in flight. active_locations above MAX_LOCATIONS evaluates MAX_LOCATIONS
// locations, zero gives no words. Write configuration only while idle. Reading a slot
// never loaded returns whatever the memory holds.
module gaussian_kernel_row_evaluator_unit import gkre_pkg::*; #(
  parameter int MAX_LOCATIONS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [ScaleBits-1:0]  cfg_wdata_i
);

  localparam int AddrW = (MAX_LOCATIONS > 1) ? $clog2(MAX_LOCATIONS) : 1;
  localparam int MemW  = 2 * CoordBits;
  localparam logic [CountBits-1:0] MaxCnt = CountBits'(MAX_LOCATIONS);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } seq_state_e;

  // Configuration registers
  logic [CountBits-1:0] active_q;
  logic [ScaleBits-1:0] inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= CountBits'(64);
      inv_q    <= ScaleBits'(12800);
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CfgActiveLocations: active_q <= cfg_wdata_i[CountBits-1:0];
        CfgInvScaleSq:      inv_q    <= cfg_wdata_i;
        default:            ;
      endcase
    end
  end

  // Handshake bookkeeping
  logic in_acc, adv, pipe_busy, pipe_valid;
  logic rd_valid_q;
  seq_state_e state_q;
  loc_tag_t pipe_tag;
  logic [KernelBits-1:0] pipe_kernel;

  logic out_valid_q;
  out_word_t out_word_q;

  // Advance the whole read/compute path unless the output word is held
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle) || rd_valid_q || pipe_busy;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Location memory: one write port for loads, one registered read port for the sweep
  logic [MemW-1:0] mem_q [MAX_LOCATIONS];
  logic [MemW-1:0] rd_q;
  logic [CountBits-1:0] idx_q, cnt_q;
  logic signed [CoordBits-1:0] qx_q, qy_q;
  loc_tag_t rd_tag_q;

  logic [CountBits-1:0] req_cnt;
  assign req_cnt = (active_q > MaxCnt) ? MaxCnt : active_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && in_word_i.operation == OpLoad &&
        CountBits'(in_word_i.slot) < MaxCnt) begin
      mem_q[in_word_i.slot[AddrW-1:0]] <= {in_word_i.coord_y, in_word_i.coord_x};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && state_q == StRun) begin
      rd_q           <= mem_q[idx_q[AddrW-1:0]];
      rd_tag_q.index <= idx_q[IndexBits-1:0];
      rd_tag_q.last  <= (idx_q == cnt_q - CountBits'(1));
    end
  end

  // Hold the query point for the whole sweep
  always_ff @(posedge clk_i) begin
    if (in_acc && in_word_i.operation == OpEvaluate) begin
      qx_q  <= in_word_i.coord_x;
      qy_q  <= in_word_i.coord_y;
      cnt_q <= req_cnt;
    end
  end

  // Sweep sequencer: issue one memory read per advancing cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      idx_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        rd_valid_q <= (state_q == StRun);
      end
      case (state_q)
        StIdle: begin
          if (in_acc && in_word_i.operation == OpEvaluate && req_cnt != '0) begin
            state_q <= StRun;
            idx_q   <= '0;
          end
        end
        StRun: begin
          if (adv) begin
            idx_q <= idx_q + CountBits'(1);
            if (idx_q == cnt_q - CountBits'(1)) begin
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  gkre_kernel_pipe u_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (rd_valid_q),
    .tag_i    (rd_tag_q),
    .qx_i     (qx_q),
    .qy_i     (qy_q),
    .lx_i     (rd_q[CoordBits-1:0]),
    .ly_i     (rd_q[MemW-1:CoordBits]),
    .inv_i    (inv_q),
    .valid_o  (pipe_valid),
    .busy_o   (pipe_busy),
    .tag_o    (pipe_tag),
    .kernel_o (pipe_kernel)
  );

  // Output word register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= pipe_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_word_q.location_index <= pipe_tag.index;
      out_word_q.kernel_value   <= pipe_kernel;
      out_word_q.last           <= pipe_tag.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

>>> rtl/core/gkre_kernel_pipe.sv
// Four-stage kernel arithmetic pipeline: distance, exponent, table fraction, scale.
module gkre_kernel_pipe import gkre_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  loc_tag_t                    tag_i,
  input  logic signed [CoordBits-1:0] qx_i,
  input  logic signed [CoordBits-1:0] qy_i,
  input  logic signed [CoordBits-1:0] lx_i,
  input  logic signed [CoordBits-1:0] ly_i,
  input  logic [ScaleBits-1:0]        inv_i,
  output logic                        valid_o,
  output logic                        busy_o,
  output loc_tag_t                    tag_o,
  output logic [KernelBits-1:0]       kernel_o
);

  localparam int DxW = CoordBits + 1;
  localparam int SqW = 2 * DxW;
  localparam int D2W = SqW + 1;
  localparam int TW  = D2W + ScaleBits;
  localparam int UW  = TW + 1 - 18;
  localparam int PrW = 29;
  localparam int KpW = 42;

  logic [3:0] v_q;
  loc_tag_t   tag_a_q, tag_b_q, tag_c_q, tag_d_q;

  // Stage A: differences and squares
  logic signed [DxW-1:0] dx, dy;
  logic [DxW-1:0]        ax, ay;
  logic [SqW-1:0]        sqx_q, sqy_q;

  assign dx = {qx_i[CoordBits-1], qx_i} - {lx_i[CoordBits-1], lx_i};
  assign dy = {qy_i[CoordBits-1], qy_i} - {ly_i[CoordBits-1], ly_i};
  assign ax = dx[DxW-1] ? DxW'(-dx) : DxW'(dx);
  assign ay = dy[DxW-1] ? DxW'(-dy) : DxW'(dy);

  // Stage B: squared distance times the inverse scale
  logic [D2W-1:0] d2;
  logic [TW-1:0]  t_q;

  assign d2 = D2W'(sqx_q) + D2W'(sqy_q);

  // Stage C: split exponent, interpolate the fractional table
  logic [TW:0]    t_rnd;
  logic [UW-1:0]  u;
  logic [3:0]     j;
  logic [11:0]    r;
  logic [16:0]    fr_j, fr_j1, diff;
  logic [16:0]    frj_q;
  logic [PrW-1:0] prod_q;
  logic [3:0]     n_q;
  logic           cut_q;

  assign t_rnd = {1'b0, t_q} + (TW+1)'(1 << 17);
  assign u     = t_rnd[TW:18];
  assign j     = u[15:12];
  assign r     = u[11:0];
  assign fr_j  = fr_lut({1'b0, j});
  assign fr_j1 = fr_lut(5'({1'b0, j}) + 5'd1);
  assign diff  = fr_j - fr_j1;

  // Stage D: integer-part scale
  logic [PrW:0]   prod_rnd;
  logic [16:0]    fv;
  logic [KpW-1:0] kp_q;
  logic           cut_d_q;

  assign prod_rnd = {1'b0, prod_q} + (PrW+1)'(2048);
  assign fv       = frj_q - 17'(prod_rnd[PrW:12]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q   <= SqW'(ax * ax);
      sqy_q   <= SqW'(ay * ay);
      tag_a_q <= tag_i;
      t_q     <= TW'(d2 * inv_i);
      tag_b_q <= tag_a_q;
      frj_q   <= fr_j;
      prod_q  <= PrW'(diff * r);
      n_q     <= u[19:16];
      cut_q   <= (u >= UW'(CutoffU));
      tag_c_q <= tag_b_q;
      kp_q    <= KpW'(it_lut(n_q) * fv);
      cut_d_q <= cut_q;
      tag_d_q <= tag_c_q;
    end
  end

  // Round, saturate just below 1.0 (16'hFFFF), zero past the cutoff
  logic [KpW:0]        kp_rnd;
  logic [KpW-24:0]     k_full;

  assign kp_rnd = {1'b0, kp_q} + (KpW+1)'(1 << 23);
  assign k_full = kp_rnd[KpW:24];

  always_comb begin
    if (cut_d_q) begin
      kernel_o = '0;
    end else if (k_full > (KpW-23)'(16'hFFFF)) begin
      kernel_o = 16'hFFFF;
    end else begin
      kernel_o = k_full[KernelBits-1:0];
    end
  end

  assign valid_o = v_q[3];
  assign tag_o   = tag_d_q;
  assign busy_o  = |v_q;

endmodule

>>> rtl/core/gkre_checker.sv
// Port-level checker for the kernel row evaluator and its bind.
module gkre_checker import gkre_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input out_word_t            out_word_o
);

  logic [IndexBits-1:0] exp_idx_q;

  // Track the index the next result word must carry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
    end else if (out_valid_o && !out_stall_i) begin
      exp_idx_q <= out_word_o.last ? '0 : out_word_o.location_index + IndexBits'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  a_index_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.location_index == exp_idx_q)
    else $error("location index out of sequence");

  a_busy_mid_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.last |-> in_stall_o)
    else $error("input taken while a row is still in flight");

endmodule

bind gaussian_kernel_row_evaluator_unit gkre_checker u_gkre_checker (.*);
